// File: sv/tdns_pkg.sv
// Shared types, constants and helper functions for the TPDF dither / noise shaper.
// No dependencies; used by every design module of the block by scoped names.
package tdns_pkg;

  // Field widths
  localparam int unsigned CHAN_W   = 6;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned DEPTH_W  = 6;
  localparam int unsigned SEED_W   = 64;
  localparam int unsigned HIST_W   = 40;
  // Internal word: Q1.31 plus 16 extra fraction bits, with headroom
  localparam int unsigned FRAC_EXT = 16;
  localparam int unsigned ACC_W    = 52;
  // 3*e1 - e2 and its half
  localparam int unsigned FB_W     = HIST_W + 3;
  localparam int unsigned DSUM_W   = 17;
  localparam int unsigned SHIFT_W  = 5;

  // Word-length limits and reset values
  localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 6'd16;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 6'd32;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd24;
  localparam logic [DEPTH_W-1:0] STEP_BASE   = 6'd48;
  localparam logic [SEED_W-1:0]  SEED_RESET  = 64'd1;

  // xorshift64* multiplier, split in halves
  localparam logic [63:0] MUL_STAR = 64'h2545_F491_4F6C_DD1D;
  localparam logic [31:0] MUL_LO   = MUL_STAR[31:0];
  localparam logic [31:0] MUL_HI   = MUL_STAR[63:32];

  // Internal-unit constants
  localparam logic signed [ACC_W-1:0] ACC_ONE  = 52'sd1;
  localparam logic signed [ACC_W-1:0] FULL_POS = 52'sh0_8000_0000_0000;
  localparam logic signed [ACC_W-1:0] FULL_NEG = -FULL_POS;
  localparam logic signed [ACC_W-1:0] HIST_MAX = (ACC_ONE <<< (HIST_W - 1)) - ACC_ONE;
  localparam logic signed [ACC_W-1:0] HIST_MIN = -(ACC_ONE <<< (HIST_W - 1));

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BIT_DEPTH = 2'd0,
    CFG_SHAPING   = 2'd1,
    CFG_RNG_SEED  = 2'd2
  } cfg_index_t;

  // History memory ports
  typedef struct packed {
    logic              en;
    logic [CHAN_W-1:0] chan;
  } hist_rd_t;

  typedef struct packed {
    logic              en;
    logic [CHAN_W-1:0] chan;
    logic [HIST_W-1:0] e1;
    logic [HIST_W-1:0] e2;
  } hist_wr_t;

  typedef struct packed {
    logic [HIST_W-1:0] e1;
    logic [HIST_W-1:0] e2;
  } hist_pair_t;

  // One xorshift64 step
  function automatic logic [63:0] xorshift(input logic [63:0] x);
    logic [63:0] y;
    y = x ^ (x >> 12);
    y = y ^ (y << 25);
    y = y ^ (y >> 27);
    return y;
  endfunction

  // Word length limited to 16..32
  function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] r;
    r = d;
    if (d < DEPTH_MIN) r = DEPTH_MIN;
    if (d > DEPTH_MAX) r = DEPTH_MAX;
    return r;
  endfunction

endpackage

// File: sv/tpdf_dither_noise_shaper.sv
// Top level of the TPDF dither / noise shaper: config registers, six-stage
// pipeline, output register. Depends on tdns_pkg, tdns_hist, tdns_rng, tdns_draw_mul.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  cfg     | cfg_valid / cfg_ready   | cfg_index[1:0], cfg_data[63:0]
//  smp     | smp_valid / smp_ready   | sample[31:0] signed, channel[5:0]
//  res     | res_valid / res_ready   | quantized[31:0] signed, clipped
//
// One sample per clock unless a hazard or a waiting result holds smp_ready low;
// a result passes stages 1 to 6 and then the output register. A shaping sample
// whose channel matches one still in the six pipeline stages waits until that
// one has written its error back to the history memory; interleaved streams of
// seven or more channels run free of hazard stalls. Reset is synchronous; history
// valid bits clear at once, no clearing pass. Stages advance independently, so
// beats are taken while a result waits on res_ready as long as a stage has room.
module tpdf_dither_noise_shaper #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [tdns_pkg::SEED_W-1:0]          cfg_data,
  input  logic                                 smp_valid,
  output logic                                 smp_ready,
  input  logic signed [tdns_pkg::SAMPLE_W-1:0] sample,
  input  logic [tdns_pkg::CHAN_W-1:0]          channel,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic signed [tdns_pkg::SAMPLE_W-1:0] quantized,
  output logic                                 clipped
);

  localparam int unsigned NST   = 6;
  localparam int unsigned ACC_W = tdns_pkg::ACC_W;
  localparam int unsigned HW    = tdns_pkg::HIST_W;

  // ---------------------------------------------------------------- config
  logic [tdns_pkg::DEPTH_W-1:0] bit_depth;
  logic                         shaping_enable;
  logic                         cfg_fire;
  logic                         hist_clr;
  logic                         seed_load;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    hist_clr  = 1'b0;
    seed_load = 1'b0;
    if (cfg_fire) begin
      unique case (cfg_index)
        tdns_pkg::CFG_BIT_DEPTH: hist_clr = 1'b1;
        tdns_pkg::CFG_SHAPING:   hist_clr = 1'b1;
        tdns_pkg::CFG_RNG_SEED: begin
          hist_clr  = 1'b1;
          seed_load = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth      <= tdns_pkg::DEPTH_RESET;
      shaping_enable <= 1'b1;
    end else if (cfg_fire) begin
      if (cfg_index == tdns_pkg::CFG_BIT_DEPTH) bit_depth <= cfg_data[tdns_pkg::DEPTH_W-1:0];
      if (cfg_index == tdns_pkg::CFG_SHAPING)   shaping_enable <= cfg_data[0];
    end
  end

  // Quantizer step derived from the clamped word length
  logic [tdns_pkg::DEPTH_W-1:0]       depth_c;
  logic [tdns_pkg::DEPTH_W-1:0]       step_k;
  logic [tdns_pkg::SHIFT_W-1:0]       dsh;
  logic signed [ACC_W-1:0]            step_v;
  logic signed [ACC_W-1:0]            half_v;
  logic signed [ACC_W-1:0]            qmax;

  assign depth_c = tdns_pkg::clamp_depth(bit_depth);
  assign step_k  = tdns_pkg::STEP_BASE - depth_c;
  assign dsh     = tdns_pkg::SHIFT_W'(tdns_pkg::DEPTH_MAX - depth_c);
  assign step_v  = tdns_pkg::ACC_ONE <<< step_k;
  assign half_v  = step_v >>> 1;
  assign qmax    = tdns_pkg::FULL_POS - step_v;

  // ---------------------------------------------------------- stage control
  logic [NST:1]                st_valid;
  logic [NST:1]                st_act;
  logic [NST:1]                st_we;
  logic [tdns_pkg::CHAN_W-1:0] st_ch  [NST:1];
  logic [tdns_pkg::SAMPLE_W-1:0] st_raw [NST:1];
  logic [NST+1:1]              en;
  logic                        in_act;
  logic                        in_we;
  logic                        hazard;
  logic                        smp_fire;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en[NST+1] = !res_valid || res_ready;
    for (int i = NST; i >= 1; i--) begin
      en[i] = !st_valid[i] || en[i+1];
    end
  end

  assign in_act = ({1'b0, channel} < (tdns_pkg::CHAN_W+1)'(MAX_CHANNELS))
                  && !((depth_c == tdns_pkg::DEPTH_MAX) && !shaping_enable);
  assign in_we  = in_act && shaping_enable;

  // Interlock: same channel still on its way to write-back
  always_comb begin
    hazard = 1'b0;
    for (int i = 1; i <= NST; i++) begin
      if (st_valid[i] && st_we[i] && (st_ch[i] == channel)) hazard = 1'b1;
    end
  end

  assign smp_ready = en[1] && !(in_we && hazard);
  assign smp_fire  = smp_valid && smp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else begin
      if (en[1]) st_valid[1] <= smp_fire;
      for (int i = 2; i <= NST; i++) begin
        if (en[i]) st_valid[i] <= st_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      st_act[1] <= in_act;
      st_we[1]  <= in_we;
      st_ch[1]  <= channel;
      st_raw[1] <= sample;
    end
    for (int i = 2; i <= NST; i++) begin
      if (en[i]) begin
        st_act[i] <= st_act[i-1];
        st_we[i]  <= st_we[i-1];
        st_ch[i]  <= st_ch[i-1];
        st_raw[i] <= st_raw[i-1];
      end
    end
  end

  // -------------------------------------------------------- generator, history
  logic [63:0] draw_a;
  logic [63:0] draw_b;
  logic [63:0] da1;
  logic [63:0] db1;

  tdns_rng u_rng (
    .clk       (clk),
    .rst       (rst),
    .seed_load (seed_load),
    .seed      (cfg_data),
    .step      (smp_fire && in_act),
    .draw_a    (draw_a),
    .draw_b    (draw_b)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      da1 <= draw_a;
      db1 <= draw_b;
    end
  end

  tdns_pkg::hist_rd_t   hrd;
  tdns_pkg::hist_wr_t   hwr;
  tdns_pkg::hist_pair_t hdata;

  assign hrd.en   = smp_fire && in_we;
  assign hrd.chan = channel;

  tdns_hist #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .clr     (hist_clr),
    .rd      (hrd),
    .rd_data (hdata),
    .wr      (hwr)
  );

  // Dither draws: partial products in stage 2, tops in stage 3
  logic signed [15:0] ta3;
  logic signed [15:0] tb3;

  tdns_draw_mul u_mul_a (
    .clk    (clk),
    .en_pp  (en[2]),
    .en_top (en[3]),
    .state  (da1),
    .top    (ta3)
  );

  tdns_draw_mul u_mul_b (
    .clk    (clk),
    .en_pp  (en[2]),
    .en_top (en[3]),
    .state  (db1),
    .top    (tb3)
  );

  // --------------------------------------------------------------- datapath
  logic signed [HW-1:0]                h_e1;
  logic signed [HW-1:0]                h_e2;
  logic signed [tdns_pkg::FB_W-1:0]    t3_1;
  logic signed [tdns_pkg::FB_W-1:0]    t3_2;
  logic signed [HW-1:0]                e1_q [NST:2];
  logic signed [47:0]                  x2;
  logic signed [tdns_pkg::FB_W-1:0]    fbh2;
  logic signed [tdns_pkg::FB_W-1:0]    fb2;
  logic signed [ACC_W-1:0]             shaped2;
  logic signed [ACC_W-1:0]             shaped_q [NST:3];
  logic signed [tdns_pkg::DSUM_W-1:0]  dsum3;
  logic signed [ACC_W-1:0]             dith3;
  logic signed [ACC_W-1:0]             v3;
  logic signed [ACC_W-1:0]             v4;
  logic signed [ACC_W-1:0]             rnd4;
  logic signed [ACC_W-1:0]             q4;
  logic signed [ACC_W-1:0]             q5;
  logic signed [ACC_W-1:0]             qs5;
  logic                                clip5;
  logic signed [ACC_W-1:0]             qs6;
  logic                                clip6;
  logic signed [ACC_W-1:0]             err6;
  logic signed [HW-1:0]                err40;

  // Stage 1: 3*e1 - e2 from the history read
  assign h_e1 = hdata.e1;
  assign h_e2 = hdata.e2;
  assign t3_1 = (tdns_pkg::FB_W'(h_e1) <<< 1) + tdns_pkg::FB_W'(h_e1)
                - tdns_pkg::FB_W'(h_e2);

  // Stage 2: shaped = x - floor((3*e1 - e2) / 2)
  assign x2      = {st_raw[2], {tdns_pkg::FRAC_EXT{1'b0}}};
  assign fbh2    = t3_2 >>> 1;
  assign fb2     = st_we[2] ? fbh2 : '0;
  assign shaped2 = ACC_W'(x2) - ACC_W'(fb2);

  // Stage 3: add scaled TPDF dither
  assign dsum3 = tdns_pkg::DSUM_W'(ta3) + tdns_pkg::DSUM_W'(tb3);
  assign dith3 = ACC_W'(dsum3) <<< dsh;
  assign v3    = shaped_q[3] + dith3;

  // Stage 4: round half away from zero to a multiple of the step
  assign rnd4 = v4[ACC_W-1] ? (half_v - tdns_pkg::ACC_ONE) : half_v;
  assign q4   = (v4 + rnd4) & ~(step_v - tdns_pkg::ACC_ONE);

  // Stage 5: saturate to the Q1.31 range
  always_comb begin
    qs5   = q5;
    clip5 = 1'b0;
    priority if (q5 > qmax) begin
      qs5   = qmax;
      clip5 = 1'b1;
    end else if (q5 < tdns_pkg::FULL_NEG) begin
      qs5   = tdns_pkg::FULL_NEG;
      clip5 = 1'b1;
    end else begin
      qs5   = q5;
    end
  end

  // Stage 6: new quantization error, saturated to 40 bits
  assign err6 = qs6 - shaped_q[NST];

  always_comb begin
    priority if (err6 > tdns_pkg::HIST_MAX) begin
      err40 = tdns_pkg::HIST_MAX[HW-1:0];
    end else if (err6 < tdns_pkg::HIST_MIN) begin
      err40 = tdns_pkg::HIST_MIN[HW-1:0];
    end else begin
      err40 = err6[HW-1:0];
    end
  end

  assign hwr.en   = en[NST+1] && st_valid[NST] && st_we[NST];
  assign hwr.chan = st_ch[NST];
  assign hwr.e1   = err40;
  assign hwr.e2   = e1_q[NST];

  // Datapath stage registers
  always_ff @(posedge clk) begin
    if (en[2]) begin
      t3_2    <= t3_1;
      e1_q[2] <= h_e1;
    end
    if (en[3]) begin
      shaped_q[3] <= shaped2;
      e1_q[3]     <= e1_q[2];
    end
    if (en[4]) begin
      v4          <= v3;
      shaped_q[4] <= shaped_q[3];
      e1_q[4]     <= e1_q[3];
    end
    if (en[5]) begin
      q5          <= q4;
      shaped_q[5] <= shaped_q[4];
      e1_q[5]     <= e1_q[4];
    end
    if (en[6]) begin
      qs6         <= qs5;
      clip6       <= clip5;
      shaped_q[6] <= shaped_q[5];
      e1_q[6]     <= e1_q[5];
    end
  end

  // ----------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en[NST+1]) begin
      res_valid <= st_valid[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST+1]) begin
      quantized <= st_act[NST] ? qs6[47:16] : st_raw[NST];
      clipped   <= st_act[NST] && clip6;
    end
  end

endmodule

// File: sv/tdns_hist.sv
// Per-channel error history memory: {e1, e2} pairs, registered read port.
// Valid bit per entry so that reset and configuration clears act at once.
// Depends on tdns_pkg.
module tdns_hist #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr,
  input  tdns_pkg::hist_rd_t   rd,
  output tdns_pkg::hist_pair_t rd_data,
  input  tdns_pkg::hist_wr_t   wr
);

  localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [2*tdns_pkg::HIST_W-1:0] mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]       hv;
  logic [2*tdns_pkg::HIST_W-1:0] rdq;
  logic                          rdv;

  // Storage: write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.chan[AW-1:0]] <= {wr.e1, wr.e2};
    end
    if (rd.en) begin
      rdq <= mem[rd.chan[AW-1:0]];
    end
  end

  // Entry valid bits; an entry never written since a clear reads as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      hv  <= '0;
      rdv <= 1'b0;
    end else begin
      if (wr.en) hv[wr.chan[AW-1:0]] <= 1'b1;
      if (rd.en) rdv <= hv[rd.chan[AW-1:0]];
    end
  end

  assign rd_data = rdv ? tdns_pkg::hist_pair_t'(rdq) : '0;

endmodule

// File: sv/tdns_rng.sv
// xorshift64 state register; gives the two states of one item's draw pair.
// Depends on tdns_pkg.
module tdns_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_load,
  input  logic [63:0] seed,
  input  logic        step,
  output logic [63:0] draw_a,
  output logic [63:0] draw_b
);

  logic [63:0] rng_word;

  // Two chained steps per item
  assign draw_a = tdns_pkg::xorshift(rng_word);
  assign draw_b = tdns_pkg::xorshift(draw_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_word <= tdns_pkg::SEED_RESET;
    end else if (seed_load) begin
      rng_word <= seed;
    end else if (step) begin
      rng_word <= draw_b;
    end
  end

endmodule

// File: sv/tdns_draw_mul.sv
// Star multiply of one xorshift state, bits 63:48 of the 64-bit product.
// Two stages: three 32x32 partial products, then their top-half sum.
// Depends on tdns_pkg.
module tdns_draw_mul (
  input  logic               clk,
  input  logic               en_pp,
  input  logic               en_top,
  input  logic [63:0]        state,
  output logic signed [15:0] top
);

  logic [63:0] pp_ll;
  logic [31:0] pp_hl;
  logic [31:0] pp_lh;
  logic [31:0] hi_sum;

  // Partial products; the cross terms only matter mod 2^32
  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp_ll <= state[31:0] * tdns_pkg::MUL_LO;
      pp_hl <= state[63:32] * tdns_pkg::MUL_LO;
      pp_lh <= state[31:0] * tdns_pkg::MUL_HI;
    end
  end

  assign hi_sum = pp_ll[63:32] + pp_hl + pp_lh;

  always_ff @(posedge clk) begin
    if (en_top) begin
      top <= hi_sum[31:16];
    end
  end

endmodule

// File: sv/tdns_checker.sv
// Port-level checks for the TPDF dither / noise shaper, bound to its top level.
// Depends on tpdf_dither_noise_shaper port names only.
module tdns_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] quantized,
  input logic        clipped
);

  // A waiting result beat holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(quantized) && $stable(clipped))
    else $error("result beat changed while stalled");

  // A clipped result sits at negative full scale or at the top code
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    res_valid && clipped |->
      (quantized == 32'h8000_0000) || (!quantized[31] && (&quantized[30:16])))
    else $error("clipped result not at a rail");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind tpdf_dither_noise_shaper tdns_checker u_tdns_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .quantized (quantized),
  .clipped   (clipped)
);

// File: tb/tb.sv
// Self-checking testbench for tpdf_dither_noise_shaper: random and directed samples,
// register writes between sample runs, a per-beat predictor and in-order result checks.
// Depends on tdns_pkg and the tpdf_dither_noise_shaper RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_CH       = 8;
  localparam int unsigned RAND_ITEMS   = 1450;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned MISS_SHOWN   = 10;
  // Register index past the end of the map; writes there are ignored
  localparam logic [1:0]  CFG_NONE     = 2'd3;

  localparam logic [63:0] XS_MULT   = 64'h2545_F491_4F6C_DD1D;
  localparam longint      FULL_UNIT = longint'(1) <<< 47;
  localparam longint      ERR_HI    = (longint'(1) <<< 39) - 1;
  localparam longint      ERR_LO    = -(longint'(1) <<< 39);

  typedef enum logic [1:0] {
    ITEM_SAMPLE,
    ITEM_CFG,
    ITEM_DRAIN,
    ITEM_PHASE
  } item_kind_t;

  typedef struct {
    item_kind_t         kind;
    logic signed [31:0] smp;
    logic [5:0]         ch;
    logic [1:0]         idx;
    logic [63:0]        data;
    int unsigned        send_pct;
    int unsigned        recv_pct;
  } plan_item_t;

  typedef struct packed {
    logic signed [31:0] quantized;
    logic               clipped;
  } quant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [1:0]                           cfg_index = 2'd0;
  logic [tdns_pkg::SEED_W-1:0]          cfg_data  = '0;
  logic                                 smp_valid = 1'b0;
  logic                                 smp_ready;
  logic signed [tdns_pkg::SAMPLE_W-1:0] sample    = '0;
  logic [tdns_pkg::CHAN_W-1:0]          channel   = '0;
  logic                                 res_valid;
  logic                                 res_ready = 1'b0;
  logic signed [tdns_pkg::SAMPLE_W-1:0] quantized;
  logic                                 clipped;

  plan_item_t  pending_beats[$];
  quant_t      expected_quant[$];
  int unsigned miss_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Predictor state
  logic [5:0]  cur_depth;
  logic        cur_shape;
  logic [63:0] rng_state;
  longint      hist_e1 [NUM_CH];
  longint      hist_e2 [NUM_CH];

  tpdf_dither_noise_shaper #(.MAX_CHANNELS(NUM_CH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .sample    (sample),
    .channel   (channel),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .quantized (quantized),
    .clipped   (clipped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_errors();
    for (int i = 0; i < NUM_CH; i++) begin
      hist_e1[i] = 0;
      hist_e2[i] = 0;
    end
  endfunction

  // One xorshift64* step; top 16 bits of the scrambled word as a signed value
  function automatic longint dither_draw();
    logic [63:0] s;
    logic [63:0] p;
    s = rng_state;
    s = s ^ (s >> 12);
    s = s ^ (s << 25);
    s = s ^ (s >> 27);
    rng_state = s;
    p = s * XS_MULT;
    return longint'($signed(p[63:48]));
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [63:0] data);
    case (idx)
      tdns_pkg::CFG_BIT_DEPTH: cur_depth = data[5:0];
      tdns_pkg::CFG_SHAPING:   cur_shape = data[0];
      tdns_pkg::CFG_RNG_SEED:  rng_state = data;
      default:                 return;
    endcase
    clear_errors();
  endfunction

  function automatic quant_t predict_quant(logic signed [31:0] smp, logic [5:0] ch);
    quant_t      res;
    int unsigned depth;
    int unsigned k;
    longint      x;
    longint      shaped;
    longint      fb;
    longint      dith;
    longint      v;
    longint      mag;
    longint      q;
    longint      qmax;
    longint      err;
    logic [63:0] r;
    depth = 32'(cur_depth);
    if (depth < tdns_pkg::DEPTH_MIN) depth = 32'(tdns_pkg::DEPTH_MIN);
    if (depth > tdns_pkg::DEPTH_MAX) depth = 32'(tdns_pkg::DEPTH_MAX);
    res.clipped   = 1'b0;
    res.quantized = smp;
    // Passthrough: unshaped full depth, or a channel without history
    if (ch >= NUM_CH || (depth == tdns_pkg::DEPTH_MAX && !cur_shape))
      return res;

    x = longint'(smp) * 65536;
    shaped = x;
    if (cur_shape) begin
      fb = (3 * hist_e1[ch] - hist_e2[ch]) >>> 1;  // floor of half
      shaped = x - fb;
    end

    dith = dither_draw();
    dith = dith + dither_draw();
    dith = dith * (longint'(1) <<< (32 - depth));
    v = shaped + dith;

    // Round half away from zero to a multiple of the step
    k = 48 - depth;
    mag = (v < 0) ? -v : v;
    r = (64'(mag) + (64'd1 << (k - 1))) >> k;
    q = longint'(r << k);
    if (v < 0) q = -q;

    qmax = FULL_UNIT - (longint'(1) <<< k);
    if (q > qmax) begin
      q = qmax;
      res.clipped = 1'b1;
    end else if (q < -FULL_UNIT) begin
      q = -FULL_UNIT;
      res.clipped = 1'b1;
    end

    if (cur_shape) begin
      err = q - shaped;
      if (err > ERR_HI) err = ERR_HI;
      if (err < ERR_LO) err = ERR_LO;
      hist_e2[ch] = hist_e1[ch];
      hist_e1[ch] = err;
    end

    res.quantized = 32'(q >>> 16);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus plan helpers
  // ---------------------------------------------------------------------------

  function automatic void add_sample(logic signed [31:0] smp, logic [5:0] ch);
    plan_item_t it;
    it = '{kind: ITEM_SAMPLE, smp: smp, ch: ch, idx: '0, data: '0, send_pct: 0, recv_pct: 0};
    pending_beats.push_back(it);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [63:0] data);
    plan_item_t it;
    it = '{kind: ITEM_CFG, smp: '0, ch: '0, idx: idx, data: data, send_pct: 0, recv_pct: 0};
    pending_beats.push_back(it);
  endfunction

  function automatic void add_drain();
    plan_item_t it;
    it = '{kind: ITEM_DRAIN, smp: '0, ch: '0, idx: '0, data: '0, send_pct: 0, recv_pct: 0};
    pending_beats.push_back(it);
  endfunction

  function automatic void add_phase(int unsigned s_pct, int unsigned r_pct);
    plan_item_t it;
    it = '{kind: ITEM_PHASE, smp: '0, ch: '0, idx: '0, data: '0,
           send_pct: s_pct, recv_pct: r_pct};
    pending_beats.push_back(it);
  endfunction

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF - $urandom_range(0, 255);
      1:       return 32'sh8000_0000 + $urandom_range(0, 255);
      2, 3:    return $urandom_range(0, 131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // Word length in the low bits, noise above (ignored by the block)
  function automatic logic [63:0] pick_depth_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1:    w[5:0] = tdns_pkg::DEPTH_MIN;
      2:       w[5:0] = tdns_pkg::DEPTH_MAX;
      3:       w[5:0] = 6'($urandom_range(0, 63));
      default: w[5:0] = 6'($urandom_range(16, 32));
    endcase
    return w;
  endfunction

  function automatic void flag_miss(string msg);
    miss_count++;
    if (miss_count <= MISS_SHOWN)
      $display("mismatch @%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Sample / config driver: predicts at each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    plan_item_t head;
    logic       smp_busy;
    logic       cfg_busy;
    logic       next_smp;
    logic       next_cfg;
    if (rst) begin
      smp_valid <= 1'b0;
      cfg_valid <= 1'b0;
      cur_depth = tdns_pkg::DEPTH_RESET;
      cur_shape = 1'b1;
      rng_state = tdns_pkg::SEED_RESET;
      clear_errors();
      expected_quant.delete();
    end else begin
      smp_busy = smp_valid && !smp_ready;
      cfg_busy = cfg_valid && !cfg_ready;
      if (smp_valid && smp_ready)
        expected_quant.push_back(predict_quant(sample, channel));
      if (cfg_valid && cfg_ready)
        apply_cfg(cfg_index, cfg_data);
      next_smp = smp_busy;
      next_cfg = cfg_busy;

      if (!smp_busy && !cfg_busy) begin
        while (pending_beats.size() > 0 && pending_beats[0].kind == ITEM_PHASE) begin
          send_idle_pct  = pending_beats[0].send_pct;
          recv_stall_pct = pending_beats[0].recv_pct;
          void'(pending_beats.pop_front());
        end
        if (pending_beats.size() > 0) begin
          head = pending_beats[0];
          case (head.kind)
            ITEM_SAMPLE: begin
              if ($urandom_range(99) >= send_idle_pct) begin
                sample   <= head.smp;
                channel  <= head.ch;
                next_smp = 1'b1;
                void'(pending_beats.pop_front());
              end
            end
            // register writes only once the pipeline has emptied
            ITEM_CFG: begin
              if (expected_quant.size() == 0) begin
                cfg_index <= head.idx;
                cfg_data  <= head.data;
                next_cfg  = 1'b1;
                void'(pending_beats.pop_front());
              end
            end
            ITEM_DRAIN: begin
              if (expected_quant.size() == 0)
                void'(pending_beats.pop_front());
            end
            default: ;
          endcase
        end
      end
      smp_valid <= next_smp;
      cfg_valid <= next_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and backpressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    quant_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_quant.size() == 0) begin
          flag_miss($sformatf("unexpected beat quantized=%h clipped=%b", quantized, clipped));
        end else begin
          want = expected_quant.pop_front();
          if (quantized !== want.quantized)
            flag_miss($sformatf("quantized exp %h got %h", want.quantized, quantized));
          if (clipped !== want.clipped)
            flag_miss($sformatf("clipped exp %b got %b (quantized %h)",
                                want.clipped, clipped, want.quantized));
        end
      end
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tpdf_dither_noise_shaper regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : main_proc
    int unsigned n_rand;
    int unsigned seg_len;
    int unsigned pattern;
    int unsigned k;
    int unsigned base;
    int unsigned ch0;
    int unsigned phase_step;
    logic        rail;

    add_phase(17, 66);

    // Directed: defaults (depth 24, shaping on, seed 1)
    add_sample(32'sh7FFF_FFFF, 6'd0);
    add_sample(32'sh8000_0000, 6'd1);
    add_sample(32'sh0000_0000, 6'd2);
    add_sample(-32'sd1, 6'd3);
    add_sample(32'sh0000_0100, 6'd7);
    add_sample(32'sh1234_5678, 6'd8);    // channel past the history: passthrough
    add_sample(32'sh8765_4321, 6'd63);
    // shallowest depth, flat dither, rails clip
    add_cfg(tdns_pkg::CFG_BIT_DEPTH, {58'd0, tdns_pkg::DEPTH_MIN});
    add_cfg(tdns_pkg::CFG_SHAPING, 64'd0);
    add_sample(32'sh7FFF_FFFF, 6'd0);
    add_sample(32'sh8000_0000, 6'd5);
    add_sample(32'sh0000_8000, 6'd4);
    // full depth without shaping: passthrough
    add_cfg(tdns_pkg::CFG_BIT_DEPTH, {58'd0, tdns_pkg::DEPTH_MAX});
    add_sample(32'sh5A5A_A5A5, 6'd0);
    add_sample(32'shA5A5_5A5A, 6'd6);
    // full depth with shaping
    add_cfg(tdns_pkg::CFG_SHAPING, 64'd1);
    add_sample(32'sh7FFF_FFFF, 6'd0);
    add_sample(32'sh8000_0000, 6'd0);
    add_sample(32'sh0000_0003, 6'd0);
    // zero seed: generator stuck at zero, no dither
    add_cfg(tdns_pkg::CFG_RNG_SEED, 64'd0);
    add_sample(32'sh0001_2345, 6'd1);
    add_sample(-32'sd77777, 6'd1);
    // depth field below and above the legal range
    add_cfg(tdns_pkg::CFG_BIT_DEPTH, 64'hFFFF_FFFF_FFFF_FFC0);
    add_sample(32'sh4000_0000, 6'd2);
    add_sample(32'shC000_0001, 6'd2);
    add_cfg(tdns_pkg::CFG_BIT_DEPTH, 64'h0000_0000_0000_003F);
    add_sample(32'sh0FED_CBA9, 6'd3);
    // unmapped index, then an all-ones seed
    add_cfg(CFG_NONE, 64'hDEAD_BEEF_0BAD_F00D);
    add_sample(32'sh7654_3210, 6'd4);
    add_cfg(tdns_pkg::CFG_RNG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_sample(32'sh0000_0000, 6'd5);
    add_sample(32'sh7FFF_FFFF, 6'd5);

    // Random segments: a few register writes, then a run of samples
    n_rand = 0;
    phase_step = 1;
    while (n_rand < RAND_ITEMS) begin
      if (phase_step == 1 && n_rand >= RAND_ITEMS / 3) begin
        add_phase(66, 17);
        phase_step = 2;
      end else if (phase_step == 2 && n_rand >= 2 * RAND_ITEMS / 3) begin
        add_phase(0, 0);
        phase_step = 3;
      end

      if ($urandom_range(3) != 0) add_cfg(tdns_pkg::CFG_BIT_DEPTH, pick_depth_word());
      if ($urandom_range(2) == 0) add_cfg(tdns_pkg::CFG_SHAPING, {$urandom, $urandom});
      if ($urandom_range(3) == 0) add_cfg(tdns_pkg::CFG_RNG_SEED, {$urandom, $urandom});
      if ($urandom_range(15) == 0) add_cfg(CFG_NONE, {$urandom, $urandom});
      if ($urandom_range(5) == 0) add_drain();

      pattern = $urandom_range(11);
      if (pattern == 11) begin
        // held at a rail with shaping: error history runs up to saturation
        add_cfg(tdns_pkg::CFG_BIT_DEPTH, {58'd0, tdns_pkg::DEPTH_MIN});
        add_cfg(tdns_pkg::CFG_SHAPING, 64'd1);
        seg_len = $urandom_range(100, 180);
        rail = 1'($urandom_range(1));
        ch0 = $urandom_range(NUM_CH - 1);
        for (int i = 0; i < seg_len; i++)
          add_sample(rail ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                     (i % 3 == 2) ? 6'($urandom_range(NUM_CH - 1)) : 6'(ch0));
      end else begin
        seg_len = $urandom_range(8, 60);
        k = $urandom_range(1, NUM_CH);
        base = $urandom_range(NUM_CH - 1);
        for (int i = 0; i < seg_len; i++) begin
          if (pattern <= 3)        // round robin over k channels; k = 1 stresses hazards
            add_sample(pick_sample(), 6'((base + i % k) % NUM_CH));
          else if (pattern <= 8)
            add_sample(pick_sample(), 6'($urandom_range(NUM_CH - 1)));
          else
            add_sample(pick_sample(), 6'($urandom_range(63)));
        end
      end
      n_rand += seg_len;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the plan to drain and all results to arrive
    do @(negedge clk);
    while (pending_beats.size() != 0 || expected_quant.size() != 0 || smp_valid || cfg_valid);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (miss_count == 0 && expected_quant.size() == 0)
      $display("tpdf_dither_noise_shaper regression: pass");
    else
      $display("tpdf_dither_noise_shaper regression: fail");
    $finish;
  end

endmodule

// File: sim.f
sv/tdns_pkg.sv
sv/tdns_hist.sv
sv/tdns_rng.sv
sv/tdns_draw_mul.sv
sv/tpdf_dither_noise_shaper.sv
sv/tdns_checker.sv
tb/tb.sv
